### sv/pcm_to_int32_sample_converter_top_macros.svh
// Assertion macros for the PCM sample converter checker
`ifndef PCM_TO_INT32_SAMPLE_CONVERTER_TOP_MACROS_SVH
`define PCM_TO_INT32_SAMPLE_CONVERTER_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define PCS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent
`define PCS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

### sv/pcs_pkg.sv
// Package: sample format codes and result types for the PCM converter
`timescale 1ns / 1ps
package pcs_pkg;
  typedef enum logic [2:0] {
    FMT_U8  = 3'd0,
    FMT_S16 = 3'd1,
    FMT_S32 = 3'd2,
    FMT_S64 = 3'd3,
    FMT_F32 = 3'd4,
    FMT_F64 = 3'd5,
    FMT_RSV6 = 3'd6,
    FMT_RSV7 = 3'd7
  } fmt_e;

  localparam logic [2:0] FmtReset = 3'd2;

  // Per-item conversion outcome passed to the result stage
  typedef struct packed {
    logic [31:0] sample;
    logic        clip;
  } conv_t;
endpackage

### sv/pcs_in_if.sv
// Input channel interface: raw sample bits
`timescale 1ns / 1ps
interface pcs_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] raw_bits;
  modport source (output valid, output raw_bits, input ready);
  modport sink (input valid, input raw_bits, output ready);
endinterface

### sv/pcs_out_if.sv
// Output channel interface: converted sample, clip flag and clip count
`timescale 1ns / 1ps
interface pcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_out;
  logic               clipped;
  logic        [31:0] clip_total;
  modport source (output valid, output sample_out, output clipped, output clip_total,
                  input ready);
  modport sink (input valid, input sample_out, input clipped, input clip_total,
                output ready);
endinterface

### sv/pcs_float_conv.sv
// Float to signed 32-bit conversion: scale by 2^31, round half away, saturate
`timescale 1ns / 1ps
module pcs_float_conv (
  input  logic          is_double_i,
  input  logic [63:0]   raw_i,
  output pcs_pkg::conv_t conv_o
);
  logic        sgn;
  logic [10:0] e11;
  logic [52:0] mant;     // with hidden bit, binary64 alignment
  logic        is_nan;
  logic        is_inf;
  logic signed [12:0] ue; // unbiased exponent plus 31 (value scaled by 2^31)
  logic [5:0]  rsh;
  logic [52:0] intp;
  logic [52:0] rem_mask;
  logic [52:0] rem;
  logic [52:0] half;
  logic        rnd;
  logic [32:0] mag;
  logic        big;

  always_comb begin
    if (is_double_i) begin
      sgn  = raw_i[63];
      e11  = raw_i[62:52];
      mant = {(raw_i[62:52] != 11'd0), raw_i[51:0]};
      is_nan = (raw_i[62:52] == 11'h7FF) && (raw_i[51:0] != 52'd0);
      is_inf = (raw_i[62:52] == 11'h7FF) && (raw_i[51:0] == 52'd0);
      // value*2^31 = mant * 2^(e-1023-52+31)
      ue = $signed({2'b00, raw_i[62:52]}) - 13'sd1023 + 13'sd31;
      if (raw_i[62:52] == 11'd0) ue = 13'sd1 - 13'sd1023 + 13'sd31;
    end else begin
      sgn  = raw_i[31];
      e11  = {3'd0, raw_i[30:23]};
      mant = {(raw_i[30:23] != 8'd0), raw_i[22:0], 29'd0};
      is_nan = (raw_i[30:23] == 8'hFF) && (raw_i[22:0] != 23'd0);
      is_inf = (raw_i[30:23] == 8'hFF) && (raw_i[22:0] == 23'd0);
      ue = $signed({5'd0, raw_i[30:23]}) - 13'sd127 + 13'sd31;
      if (raw_i[30:23] == 8'd0) ue = 13'sd1 - 13'sd127 + 13'sd31;
    end
    // scaled magnitude = mant * 2^(ue-52); ue >= 32 means >= 2^32, overload
    big  = is_inf || (ue >= 13'sd32);
    rsh  = '0;
    if (ue < 13'sd0) rsh = 6'd53;
    else if (ue <= 13'sd52) rsh = 6'(13'sd52 - ue);
    intp = (rsh >= 6'd53) ? 53'd0 : (mant >> rsh);
    rem_mask = (rsh >= 6'd53) ? {53{1'b1}} : ~({53{1'b1}} << rsh);
    rem  = mant & rem_mask;
    half = (rsh == 6'd0 || rsh >= 6'd54) ? 53'd0 : (53'd1 << (rsh - 6'd1));
    rnd  = (rsh != 6'd0) && (rsh <= 6'd53) && (rem >= half) && (half != 53'd0);
    if (rsh == 6'd53) rnd = mant[52];
    // ue of -1 puts the scaled value in [0.5, 1); anything lower is below one half
    if (ue < -13'sd1) rnd = 1'b0;
    mag = intp[32:0] + {32'd0, rnd};
    if (e11 == 11'd0 && mant == 53'd0) mag = '0;
    conv_o.clip = 1'b0;
    if (is_nan) begin
      conv_o.sample = 32'd0;
    end else if (big || intp[52:33] != 20'd0) begin
      conv_o.sample = sgn ? 32'h8000_0000 : 32'h7FFF_FFFF;
      conv_o.clip   = 1'b1;
    end else if (sgn) begin
      // rounded magnitude above 2^31 overloads
      conv_o.clip   = (mag > 33'h0_8000_0000);
      conv_o.sample = conv_o.clip ? 32'h8000_0000 : 32'(~mag + 33'd1);
    end else begin
      conv_o.clip   = (intp[32:0] > 33'h0_8000_0000) ||
                      ((intp[32:0] == 33'h0_8000_0000) && (rem != 53'd0));
      conv_o.sample = (mag >= 33'h0_8000_0000) ? 32'h7FFF_FFFF : mag[31:0];
    end
  end
endmodule

### sv/pcs_datapath.sv
// Format decode: integer alignment and float conversion for one item
`timescale 1ns / 1ps
module pcs_datapath (
  input  logic [2:0]     fmt_i,
  input  logic [63:0]    raw_i,
  output pcs_pkg::conv_t conv_o
);
  pcs_pkg::conv_t fconv;

  pcs_float_conv u_fconv (
    .is_double_i (fmt_i == pcs_pkg::FMT_F64),
    .raw_i       (raw_i),
    .conv_o      (fconv)
  );

  always_comb begin
    conv_o.clip = 1'b0;
    unique case (pcs_pkg::fmt_e'(fmt_i))
      pcs_pkg::FMT_U8:  conv_o.sample = {~raw_i[7], raw_i[6:0], 24'd0};
      pcs_pkg::FMT_S16: conv_o.sample = {raw_i[15:0], 16'd0};
      pcs_pkg::FMT_S32: conv_o.sample = raw_i[31:0];
      pcs_pkg::FMT_S64: conv_o.sample = raw_i[63:32];
      pcs_pkg::FMT_F32, pcs_pkg::FMT_F64: conv_o = fconv;
      default:          conv_o.sample = 32'd0;
    endcase
  end
endmodule

### sv/pcm_to_int32_sample_converter_top.sv
// Top level of the PCM to signed 32-bit sample converter
// Channel | Dir | Payload
// in_ch   | in  | raw_bits[63:0]
// out_ch  | out | sample_out[31:0], clipped, clip_total[31:0]
// cfg     | in  | cfg_we_i, cfg_wdata_i[2:0] (format code)
// One item per cycle while the output does not stall; each item passes the input register, then the result register.
// Conversion is a single combinational pass between the two registers.
// Reset: format s32, clip count zero, both stages empty.
// Output stall holds the result stage; the input stage moves on whenever it would empty.
`timescale 1ns / 1ps
module pcm_to_int32_sample_converter_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  pcs_in_if.sink     in_ch,
  pcs_out_if.source  out_ch
);
  logic [2:0]     fmt_q;
  logic           s1_vld_q;
  logic [63:0]    s1_raw_q;
  logic           s2_vld_q;
  logic [31:0]    s2_smp_q;
  logic           s2_clp_q;
  logic [31:0]    cnt_q;
  logic [31:0]    cnt_d;
  logic           s2_adv;
  logic           s1_adv;
  pcs_pkg::conv_t conv;

  assign s2_adv      = s1_vld_q && (!s2_vld_q || out_ch.ready);
  assign s1_adv      = !s1_vld_q || s2_adv;
  assign in_ch.ready = s1_adv;

  pcs_datapath u_dp (
    .fmt_i  (fmt_q),
    .raw_i  (s1_raw_q),
    .conv_o (conv)
  );

  assign cnt_d = (conv.clip && cnt_q != 32'hFFFF_FFFF) ? cnt_q + 32'd1 : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= pcs_pkg::FmtReset;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) fmt_q <= cfg_wdata_i;
      if (s1_adv) s1_vld_q <= in_ch.valid;
      if (s2_adv) begin
        s2_vld_q <= 1'b1;
        cnt_q    <= cnt_d;
      end else if (out_ch.ready) begin
        s2_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_ch.valid) s1_raw_q <= in_ch.raw_bits;
    if (s2_adv) begin
      s2_smp_q <= conv.sample;
      s2_clp_q <= conv.clip;
    end
  end

  assign out_ch.valid      = s2_vld_q;
  assign out_ch.sample_out = s2_smp_q;
  assign out_ch.clipped    = s2_clp_q;
  assign out_ch.clip_total = cnt_q;
endmodule

### sv/pcs_checker.sv
// Port-level checker for the converter, bound to the top level
`timescale 1ns / 1ps
`include "pcm_to_int32_sample_converter_top_macros.svh"
module pcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic        clipped,
  input logic [31:0] clip_total,
  input logic [31:0] sample_out
);
  `PCS_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(sample_out), "result dropped while stalled")
  `PCS_ASSERT_NEXT(a_cnt_mono, clk_i, rst_ni, 1'b1, clip_total >= $past(clip_total), "clip count went down")
  `PCS_ASSERT_IMPL(a_clip_val, clk_i, rst_ni, out_valid && clipped, sample_out == 32'h8000_0000 || sample_out == 32'h7FFF_FFFF, "clipped but not saturated")
  `PCS_ASSERT_IMPL(a_clip_cnt, clk_i, rst_ni, out_valid && clipped, clip_total != 32'd0, "clipped with zero count")
endmodule

bind pcm_to_int32_sample_converter_top pcs_checker u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .clipped    (out_ch.clipped),
  .clip_total (out_ch.clip_total),
  .sample_out (out_ch.sample_out)
);

### tb/sv/pcs_result_checker.sv
// Result checker: predicts each converted sample, clip flag and clip count and compares them with the block output
`timescale 1ns / 1ps
module pcs_result_checker
  import pcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  pcs_in_if          in_ch,
  pcs_out_if         out_ch,
  output int         fail_count_o,
  output int         pending_o
);
  typedef struct {
    logic [31:0] sample;
    logic        clip;
    logic [31:0] total;
  } sample_exp_t;

  sample_exp_t expected_q[$];
  fmt_e        fmt_q;
  logic [31:0] clip_count_q;

  assign pending_o = expected_q.size();

  // binary32 widened to binary64 bit by bit, so no rounding can creep in
  function automatic real f32_to_real(logic [31:0] b);
    logic [10:0] e;
    logic [22:0] fm;
    int          sh;
    fm = b[22:0];
    sh = 0;
    if (b[30:23] == 8'hFF) begin
      e = 11'h7FF;
    end else if (b[30:23] == 8'h00) begin
      if (fm == 23'd0) begin
        e = 11'd0;
      end else begin
        while (!fm[22]) begin
          fm = fm << 1;
          sh++;
        end
        fm = fm << 1;
        e = 11'd896 - 11'(sh);
      end
    end else begin
      e = {3'b000, b[30:23]} + 11'd896;
    end
    return $bitstoreal({b[31], e, fm, 29'd0});
  endfunction

  function automatic logic [31:0] scale_float(real v, logic nan, output logic clip);
    real    scaled;
    real    frac;
    longint whole;
    clip = 1'b0;
    if (nan) return 32'd0;
    scaled = v * 2147483648.0;
    if (scaled <= -2147483648.5) begin
      clip = 1'b1;
      return 32'h8000_0000;
    end
    if (scaled >= 2147483647.5) begin
      clip = scaled > 2147483648.0;
      return 32'h7FFF_FFFF;
    end
    // truncate toward zero without trusting the cast's rounding mode
    whole = longint'(scaled);
    if (scaled >= 0.0 && real'(whole) > scaled) whole--;
    if (scaled < 0.0 && real'(whole) < scaled) whole++;
    frac = scaled - real'(whole);
    if (frac >= 0.5) whole++;
    else if (frac <= -0.5) whole--;
    return whole[31:0];
  endfunction

  function automatic sample_exp_t convert_sample(logic [63:0] raw);
    sample_exp_t r;
    logic        clip;
    clip = 1'b0;
    case (fmt_q)
      FMT_U8:  r.sample = {raw[7:0], 24'd0} ^ 32'h8000_0000;
      FMT_S16: r.sample = {raw[15:0], 16'd0};
      FMT_S32: r.sample = raw[31:0];
      FMT_S64: r.sample = raw[63:32];
      FMT_F32: r.sample = scale_float(f32_to_real(raw[31:0]),
                                      raw[30:23] == 8'hFF && raw[22:0] != 0, clip);
      FMT_F64: r.sample = scale_float($bitstoreal(raw),
                                      raw[62:52] == 11'h7FF && raw[51:0] != 0, clip);
      default: r.sample = 32'd0;
    endcase
    if (clip && clip_count_q != 32'hFFFF_FFFF) clip_count_q++;
    r.clip  = clip;
    r.total = clip_count_q;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sample_exp_t e;
    if (!rst_ni) begin
      fmt_q <= fmt_e'(FmtReset);
      clip_count_q = 32'd0;
    end else begin
      if (cfg_we_i) fmt_q <= fmt_e'(cfg_wdata_i);
      if (in_ch.valid && in_ch.ready) expected_q.push_back(convert_sample(in_ch.raw_bits));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected item", out_ch.sample_out, 32'd0);
        end else begin
          e = expected_q.pop_front();
          if (out_ch.sample_out !== e.sample) report("sample_out", out_ch.sample_out, e.sample);
          if (out_ch.clipped !== e.clip) report("clipped", 32'(out_ch.clipped), 32'(e.clip));
          if (out_ch.clip_total !== e.total) report("clip_total", out_ch.clip_total, e.total);
        end
      end
    end
  end
endmodule

### tb/sv/tb_pcm_to_int32_sample_converter_top.sv
// Testbench top: clock, reset, stimulus, idling and the final verdict
`timescale 1ns / 1ps
module tb_pcm_to_int32_sample_converter_top;
  import pcs_pkg::*;

  localparam int WatchdogLimit = 5000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [2:0] cfg_wdata_i = FmtReset;
  int         fail_count;
  int         pending;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  logic       hold_req = 1'b0;
  int         hold_left = 0;
  int         quiet_cycles = 0;

  pcs_in_if  in_ch ();
  pcs_out_if out_ch ();

  pcm_to_int32_sample_converter_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  pcs_result_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_ch(in_ch), .out_ch(out_ch), .fail_count_o(fail_count), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  // receiver: random stalls, plus one long hold-off to back the block up
  always @(posedge clk_i) begin
    if (hold_req && hold_left == 0) hold_left <= 300;
    else if (hold_left > 0) hold_left <= hold_left - 1;
    out_ch.ready <= rst_ni && hold_left <= 1 && !(hold_req && hold_left == 0)
                    && ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(logic [63:0] raw);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_bits <= raw;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic set_format(fmt_e f);
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= f;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] random_raw(fmt_e f);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(3) == 0) return r;
    // floats mostly near full scale, where rounding and clipping live
    if (f == FMT_F32) r[30:23] = 8'($urandom_range(128, 100));
    if (f == FMT_F64) begin
      r[62:52] = 11'($urandom_range(1024, 1000));
      if ($urandom_range(3) == 0) begin
        r[62:52] = 11'($urandom_range(1023, 1022));
        r[51:0] = $urandom_range(1) ? 52'($urandom_range(3)) << 20
                                    : ~(52'($urandom_range(3)) << 20);
      end
    end
    return r;
  endfunction

  initial begin
    fmt_e f;
    in_ch.valid <= 1'b0;
    in_ch.raw_bits <= 64'd0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // format after reset is s32
    send_item(64'hFFFF_FFFF_8000_0000);
    send_item(64'h0000_0000_7FFF_FFFF);
    set_format(FMT_U8);
    send_item(64'h0);
    send_item(64'hFF);
    send_item(64'h80);
    set_format(FMT_S16);
    send_item(64'h8000);
    send_item(64'h7FFF);
    set_format(FMT_S64);
    send_item(64'h8000_0000_0000_0000);
    send_item(64'h7FFF_FFFF_FFFF_FFFF);
    set_format(FMT_F32);
    send_item(64'h3F80_0000);       // +1.0 saturates without a clip
    send_item(64'hBF80_0000);       // -1.0 is exact
    send_item(64'h3F80_0001);
    send_item(64'h7F80_0000);
    send_item(64'hFF80_0000);
    send_item(64'h7FC0_0000);
    send_item(64'h0000_0001);
    set_format(FMT_F64);
    send_item(64'h3FEF_FFFF_FFE0_0000); // exactly half below full scale
    send_item(64'h3FF0_0000_0000_0001);
    send_item(64'hBFF0_0000_0010_0000); // exactly half beyond negative full scale
    send_item(64'h3DF0_0000_0000_0000); // one half of an lsb
    send_item(64'hBDF0_0000_0000_0000);
    send_item(64'h7FF8_0000_0000_0000);
    set_format(FMT_RSV7);
    send_item(64'h1234_5678_9ABC_DEF0);
    set_format(FMT_RSV6);
    send_item(64'hFFFF_FFFF_FFFF_FFFF);

    for (int blk = 0; blk < 24; blk++) begin
      if (blk < 8) begin
        tx_idle_pct = 28; rx_idle_pct = 77;
      end else if (blk < 16) begin
        tx_idle_pct = 77; rx_idle_pct = 28;
      end else begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      f = $urandom_range(2) == 0 ? fmt_e'($urandom_range(7)) : fmt_e'($urandom_range(5, 4));
      set_format(f);
      if (blk == 17) hold_req <= 1'b1;
      for (int i = 0; i < 67; i++) begin
        send_item(random_raw(f));
        if (i == 2) hold_req <= 1'b0;
      end
    end
    in_ch.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

### sim.f
+incdir+sv
sv/pcs_pkg.sv
sv/pcs_in_if.sv
sv/pcs_out_if.sv
sv/pcs_float_conv.sv
sv/pcs_datapath.sv
sv/pcm_to_int32_sample_converter_top.sv
sv/pcs_checker.sv
tb/sv/pcs_result_checker.sv
tb/sv/tb_pcm_to_int32_sample_converter_top.sv
